// File: src/h264rtp_pkg.sv
`default_nettype none

package h264rtp_pkg;

  localparam int unsigned MAX_NALS_DEFAULT = 15;

  localparam logic [13:0] MTU_RESET = 14'd1400;
  localparam logic [13:0] MTU_FLOOR = 14'd1100;
  localparam logic [13:0] MTU_CEIL  = 14'd9000;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_STAP   = 2'd1;
  localparam logic [1:0] KIND_FU     = 2'd2;

  localparam logic [7:0] STAP_TYPE = 8'd24;
  localparam logic [7:0] FU_TYPE   = 8'd28;
  localparam logic [4:0] SPS_TYPE  = 5'd7;
  localparam logic [4:0] PPS_TYPE  = 5'd8;
  localparam logic [7:0] NRI_MASK  = 8'h60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH_OLD,
    ST_FRAG,
    ST_FLUSH_END
  } h264rtp_state_t;

  typedef struct packed {
    logic latch;
    logic append;
    logic open;
    logic flush;
    logic flush_mark;
    logic flush_last;
    logic frag_init;
    logic frag_step;
  } h264rtp_cmd_t;

  typedef struct packed {
    logic group_open;
    logic fits;
    logic drop;
    logic too_long;
    logic frame_last;
    logic frag_end;
    logic out_free;
  } h264rtp_status_t;

endpackage

`default_nettype wire

// File: src/h264rtp_ctrl.sv
`default_nettype none

module h264rtp_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  h264rtp_pkg::h264rtp_status_t  status,
  output h264rtp_pkg::h264rtp_cmd_t     cmd
);
  import h264rtp_pkg::*;

  h264rtp_state_t state;
  h264rtp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.fits) begin
          cmd.append = 1'b1;
          state_next = status.frame_last ? ST_FLUSH_END : ST_IDLE;
        end else if (status.group_open) begin
          state_next = ST_FLUSH_OLD;
        end else if (status.drop) begin
          state_next = ST_IDLE;
        end else if (status.too_long) begin
          cmd.frag_init = 1'b1;
          state_next    = ST_FRAG;
        end else begin
          cmd.open   = 1'b1;
          state_next = status.frame_last ? ST_FLUSH_END : ST_IDLE;
        end
      end
      ST_FLUSH_OLD: begin
        if (status.out_free) begin
          cmd.flush      = 1'b1;
          cmd.flush_mark = 1'b0;
          cmd.flush_last = status.drop || (!status.too_long && !status.frame_last);
          cmd.open       = !status.drop && !status.too_long;
          cmd.frag_init  = !status.drop && status.too_long;
          if (status.drop) begin
            state_next = ST_IDLE;
          end else if (status.too_long) begin
            state_next = ST_FRAG;
          end else begin
            state_next = status.frame_last ? ST_FLUSH_END : ST_IDLE;
          end
        end
      end
      ST_FRAG: begin
        if (status.out_free) begin
          cmd.frag_step = 1'b1;
          if (status.frag_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH_END: begin
        if (status.out_free) begin
          cmd.flush      = 1'b1;
          cmd.flush_mark = 1'b1;
          cmd.flush_last = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/h264rtp_dp.sv
`default_nettype none

module h264rtp_dp #(
  parameter int unsigned MaxNals = h264rtp_pkg::MAX_NALS_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_write,
  input  wire  [13:0]                   cfg_data,
  input  wire  [15:0]                   unit_length,
  input  wire  [7:0]                    nal_header,
  input  wire                           nal_unique,
  input  wire                           frame_last,
  input  wire                           out_stall,
  input  h264rtp_pkg::h264rtp_cmd_t     cmd,
  output h264rtp_pkg::h264rtp_status_t  status,
  output logic                          out_valid,
  output logic [1:0]                    packet_kind,
  output logic [7:0]                    header_first,
  output logic [7:0]                    header_second,
  output logic [3:0]                    nal_count,
  output logic [15:0]                   data_offset,
  output logic [15:0]                   payload_length,
  output logic                          marker,
  output logic                          last
);
  import h264rtp_pkg::*;

  logic [13:0] mtu;

  logic [15:0] len;
  logic [7:0]  hdr;
  logic        uniq;
  logic        fl;

  logic [3:0]  group_count;
  logic [15:0] group_size;
  logic [1:0]  group_nri;
  logic [7:0]  group_head_header;
  logic [15:0] group_head_length;

  logic [15:0] frag_rem;
  logic [15:0] frag_off;
  logic        frag_first;

  logic [16:0] join_size;
  logic [1:0]  nri;
  logic [4:0]  unit_type;
  logic [15:0] frag_size;

  always_comb begin
    nri        = hdr[6:5];
    unit_type  = hdr[4:0];
    join_size  = {1'b0, group_size} + 17'd2 + {1'b0, len};

    status.group_open = (group_count != 4'd0);
    status.fits       = status.group_open && (group_count < 4'(MaxNals))
                        && (join_size <= {3'b000, mtu});
    status.drop       = !uniq && ((unit_type == SPS_TYPE) || (unit_type == PPS_TYPE));
    status.too_long   = (len > {2'b00, mtu});
    status.frame_last = fl;
    status.frag_end   = (({1'b0, frag_rem} + 17'd2) <= {3'b000, mtu});
    status.out_free   = !out_valid || !out_stall;

    frag_size = status.frag_end ? frag_rem : ({2'b00, mtu} - 16'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= MTU_RESET;
    end else if (cfg_write) begin
      if (cfg_data < MTU_FLOOR) begin
        mtu <= MTU_FLOOR;
      end else if (cfg_data > MTU_CEIL) begin
        mtu <= MTU_CEIL;
      end else begin
        mtu <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      len  <= unit_length;
      hdr  <= nal_header;
      uniq <= nal_unique;
      fl   <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count       <= 4'd0;
      group_size        <= 16'd0;
      group_nri         <= 2'd0;
      group_head_header <= 8'd0;
      group_head_length <= 16'd0;
    end else if (cmd.open) begin
      group_count       <= 4'd1;
      group_size        <= len + 16'd3;
      group_nri         <= nri;
      group_head_header <= hdr;
      group_head_length <= len;
    end else if (cmd.append) begin
      group_count <= group_count + 4'd1;
      group_size  <= join_size[15:0];
      if (nri > group_nri) begin
        group_nri <= nri;
      end
    end else if (cmd.flush) begin
      group_count       <= 4'd0;
      group_size        <= 16'd0;
      group_nri         <= 2'd0;
      group_head_header <= 8'd0;
      group_head_length <= 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frag_init) begin
      frag_rem   <= len - 16'd1;
      frag_off   <= 16'd1;
      frag_first <= 1'b1;
    end else if (cmd.frag_step) begin
      frag_rem   <= frag_rem - frag_size;
      frag_off   <= frag_off + frag_size;
      frag_first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush || cmd.frag_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      header_second <= 8'd0;
      data_offset   <= 16'd0;
      marker        <= cmd.flush_mark;
      last          <= cmd.flush_last;
      if (group_count == 4'd1) begin
        packet_kind    <= KIND_SINGLE;
        header_first   <= group_head_header;
        nal_count      <= 4'd1;
        payload_length <= group_head_length;
      end else begin
        packet_kind    <= KIND_STAP;
        header_first   <= STAP_TYPE | {1'b0, group_nri, 5'd0};
        nal_count      <= group_count;
        payload_length <= group_size;
      end
    end else if (cmd.frag_step) begin
      packet_kind    <= KIND_FU;
      header_first   <= (hdr & NRI_MASK) | FU_TYPE;
      header_second  <= {frag_first, status.frag_end, 1'b0, unit_type};
      nal_count      <= 4'd1;
      data_offset    <= frag_off;
      payload_length <= frag_size;
      marker         <= status.frag_end && fl;
      last           <= status.frag_end;
    end
  end

endmodule

`default_nettype wire

// File: src/h264_nal_rtp_packetizer.sv
`default_nettype none
// A NAL is latched when accepted, then evaluated; any packet words it closes are registered.
// The controller emits one word per cycle into a single output register while the output
// does not stall; a stall at the output holds the flow.
// The next NAL is taken only when the controller idles, once the last one is through.
// Reset is synchronous: the MTU returns to 1400, the open group is emptied and the output is idle.

module h264_nal_rtp_packetizer #(
  parameter int unsigned MaxNals = h264rtp_pkg::MAX_NALS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [13:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] unit_length,
  input  wire  [7:0]  nal_header,
  input  wire         nal_unique,
  input  wire         frame_last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  packet_kind,
  output logic [7:0]  header_first,
  output logic [7:0]  header_second,
  output logic [3:0]  nal_count,
  output logic [15:0] data_offset,
  output logic [15:0] payload_length,
  output logic        marker,
  output logic        last
);
  import h264rtp_pkg::*;

  h264rtp_cmd_t    cmd;
  h264rtp_status_t status;

  h264rtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  h264rtp_dp #(
    .MaxNals (MaxNals)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .unit_length    (unit_length),
    .nal_header     (nal_header),
    .nal_unique     (nal_unique),
    .frame_last     (frame_last),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .packet_kind    (packet_kind),
    .header_first   (header_first),
    .header_second  (header_second),
    .nal_count      (nal_count),
    .data_offset    (data_offset),
    .payload_length (payload_length),
    .marker         (marker),
    .last           (last)
  );

  // Once a NAL is taken, the block is busy evaluating it in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while evaluating a NAL");

  // Only an aggregate carries more than one NAL.
  a_count_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((packet_kind == KIND_STAP) == (nal_count != 4'd1)))
    else $error("NAL count does not match packet kind");

  // The frame end is always the final word of its NAL.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && marker) |-> last)
    else $error("marker set on a word that is not last");

endmodule

`default_nettype wire
